// ===== design/stq_pkg.sv =====
// Shared types and constants for the sorted timer queue.
// No dependencies.
package stq_pkg;
	localparam int TIMER_SLOTS_DEF = 32;
	localparam int DEST_QUEUES_DEF = 4;
	localparam logic [31:0] ALL_ONES = 32'hffffffff;

	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0,
		OP_FREE  = 3'd1,
		OP_SET   = 3'd2,
		OP_START = 3'd3,
		OP_TICK  = 3'd4
	} op_t;

	localparam logic [1:0] FLAG_FREE    = 2'd0;
	localparam logic [1:0] FLAG_ALLOC   = 2'd1;
	localparam logic [1:0] FLAG_RUNNING = 2'd2;
endpackage

// ===== design/stq_cmp.sv =====
// Shared 32-bit deadline comparator used by the insert walk and expiry walk.
// Depends on stq_pkg.
module stq_cmp import stq_pkg::*; (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        le
);
	// One wide compare, reused on every step of both walks.
	assign le = (a <= b);
endmodule

// ===== design/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: slot stores, list walk sequencer.
// Depends on stq_pkg and stq_cmp.
//
// Usage: commands arrive on the s_axis channel, one word per command.
// s_axis_tdata carries operation, slot_index, message_data, dest_queue and
// delay_ticks. Results leave on m_axis: an allocate reply or one expiry
// word per due timer, tlast marking the final word caused by a command.
// Work per command: free, set data, an unknown operation and a tick with
// nothing due finish in the idle state; allocate scans up to
// min(TIMER_SLOTS, 32) slots for a free one, one slot a cycle; start walks
// the sorted list to the new timer's place, one link a cycle; a tick that
// expires k timers takes them from the list head and sends k expiry words.
// The shared comparator and the walk read port of the slot stores pace the
// walks. s_axis_tready is low while a command is being worked.
// Reset clears every slot to free, the tick count to zero and the list to
// empty. If m_axis_tready is low the sequencer holds the result word in its
// output register and waits before it loads the next one; no word is lost.
module sorted_timer_queue import stq_pkg::*; #(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
	parameter int DEST_QUEUES = DEST_QUEUES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[2:0], slot_index[7:3], message_data[39:8], dest_queue[41:40],
	// delay_ticks[73:42], zeros[79:74]
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// slot_index_out[4:0], alloc_ok[5], message_out[37:6],
	// dest_queue_out[39:38]
	output logic [39:0] m_axis_tdata,
	// result_kind
	output logic        m_axis_tuser,
	output logic        m_axis_tlast
);
	localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int AS = (TIMER_SLOTS < 32) ? TIMER_SLOTS : 32;
	localparam int QW = (DEST_QUEUES > 1) ? $clog2(DEST_QUEUES) : 1;
	localparam int CW = SW + 1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_ALLOC = 8'b0000_0010,
		ST_INS   = 8'b0000_0100,
		ST_WALK  = 8'b0000_1000,
		ST_EXP   = 8'b0001_0000,
		ST_OUT   = 8'b0010_0000,
		ST_ROUT  = 8'b0100_0000,
		ST_HEAD  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [1:0]    flags_q [TIMER_SLOTS];
	logic [31:0]   dl_mem [TIMER_SLOTS];
	logic [31:0]   msg_mem [TIMER_SLOTS];
	logic [QW-1:0] q_mem [TIMER_SLOTS];
	logic [SW-1:0] link_mem [TIMER_SLOTS];

	logic [31:0]   tick_q, early_q, dl_q;
	logic [SW-1:0] head_q, slot_q, prev_q, cur_q;
	logic [CW-1:0] total_q, n_q, k_q;
	logic [5:0]    scan_q;

	// command fields
	logic [2:0]  in_op;
	logic [4:0]  in_slot;
	logic [31:0] in_msg, in_delay;
	logic [1:0]  in_q;
	assign in_op    = s_axis_tdata[2:0];
	assign in_slot  = s_axis_tdata[7:3];
	assign in_msg   = s_axis_tdata[39:8];
	assign in_q     = s_axis_tdata[41:40];
	assign in_delay = s_axis_tdata[73:42];

	logic [SW-1:0] in_idx;
	assign in_idx = SW'(in_slot);

	logic in_valid;
	assign in_valid = ({27'd0, in_slot} < TIMER_SLOTS);

	// The destination folds into range by one compare and subtract.
	logic [1:0] in_q_mod;
	always_comb begin
		if (DEST_QUEUES == 1) in_q_mod = 2'd0;
		else if ({30'd0, in_q} >= DEST_QUEUES) in_q_mod = in_q - 2'(DEST_QUEUES);
		else in_q_mod = in_q;
	end

	// the walk read port: address chosen per state
	logic [SW-1:0] rd_addr;
	logic [31:0]   rd_dl;
	logic [SW-1:0] rd_link;
	always_comb begin
		case (state_q)
			ST_WALK: rd_addr = link_mem[prev_q];
			default: rd_addr = cur_q;
		endcase
	end
	assign rd_dl   = dl_mem[rd_addr];
	assign rd_link = link_mem[rd_addr];

	logic [31:0] cmp_a, cmp_b;
	logic        cmp_le;
	always_comb begin
		case (state_q)
			ST_EXP, ST_OUT: begin cmp_a = rd_dl; cmp_b = tick_q; end
			default: begin cmp_a = dl_q; cmp_b = rd_dl; end
		endcase
	end
	stq_cmp u_cmp (.a(cmp_a), .b(cmp_b), .le(cmp_le));

	logic        o_valid_q, o_last_q, o_kind_q, o_ok_q;
	logic [4:0]  o_slot_q;
	logic [31:0] o_msg_q;
	logic [1:0]  o_dq_q;

	logic out_free;
	assign out_free = !o_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tuser  = o_kind_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {o_dq_q, o_msg_q, o_ok_q, o_slot_q};

	logic [31:0] tick_next;
	assign tick_next = tick_q + 32'd1;

	// Payload stores need no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid && in_valid) begin
			if (in_op == OP_SET) begin
				msg_mem[in_idx] <= in_msg;
				q_mem[in_idx]   <= QW'(in_q_mod);
			end
		end
		if (state_q == ST_HEAD) begin
			dl_mem[slot_q] <= dl_q;
		end
		case (state_q)
			ST_HEAD: begin
				if (total_q == '0) link_mem[slot_q] <= '0;
				else if (cmp_le) link_mem[slot_q] <= head_q;
			end
			ST_WALK: begin
				// total_q already counts the new slot
				if (n_q >= total_q - CW'(1)) begin
					link_mem[prev_q] <= slot_q;
					link_mem[slot_q] <= '0;
				end else if (cmp_le) begin
					link_mem[prev_q] <= slot_q;
					link_mem[slot_q] <= rd_addr;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			for (int i = 0; i < TIMER_SLOTS; i++) flags_q[i] <= FLAG_FREE;
			tick_q    <= '0;
			early_q   <= ALL_ONES;
			head_q    <= '0;
			total_q   <= '0;
			o_valid_q <= 1'b0;
			o_last_q  <= 1'b0;
			o_kind_q  <= 1'b0;
			o_ok_q    <= 1'b0;
			o_slot_q  <= '0;
			o_msg_q   <= '0;
			o_dq_q    <= '0;
			scan_q    <= '0;
			slot_q    <= '0;
			prev_q    <= '0;
			cur_q     <= '0;
			n_q       <= '0;
			k_q       <= '0;
			dl_q      <= '0;
		end else begin
			// The two output states load a new word in place of a taken one.
			if (o_valid_q && m_axis_tready && state_q != ST_ROUT && state_q != ST_OUT)
				o_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						slot_q <= in_idx;
						case (in_op)
							OP_ALLOC: begin
								scan_q  <= '0;
								state_q <= ST_ALLOC;
							end
							OP_FREE: begin
								if (in_valid && flags_q[in_idx] != FLAG_RUNNING)
									flags_q[in_idx] <= FLAG_FREE;
							end
							OP_START: begin
								if (in_valid && flags_q[in_idx] != FLAG_RUNNING) begin
									dl_q    <= tick_q + in_delay;
									cur_q   <= head_q;
									state_q <= ST_HEAD;
								end
							end
							OP_TICK: begin
								tick_q <= tick_next;
								if (early_q <= tick_next) begin
									cur_q   <= head_q;
									k_q     <= '0;
									state_q <= ST_EXP;
								end
							end
							default: ;
						endcase
					end
				end
				ST_ALLOC: begin
					// One slot per cycle; scan_q stops on the free slot, or at the end.
					if (scan_q >= 6'(AS)) begin
						state_q <= ST_ROUT;
					end else if (flags_q[scan_q[SW-1:0]] == FLAG_FREE) begin
						flags_q[scan_q[SW-1:0]] <= FLAG_ALLOC;
						state_q <= ST_ROUT;
					end else begin
						scan_q <= scan_q + 6'd1;
					end
				end
				ST_ROUT: begin
					if (out_free) begin
						o_valid_q <= 1'b1;
						o_kind_q  <= 1'b0;
						o_last_q  <= 1'b1;
						o_msg_q   <= '0;
						o_dq_q    <= '0;
						if (scan_q < 6'(AS)) begin
							o_slot_q <= 5'(scan_q);
							o_ok_q   <= 1'b1;
						end else begin
							o_slot_q <= '0;
							o_ok_q   <= 1'b0;
						end
						state_q   <= ST_IDLE;
					end
				end
				ST_HEAD: begin
					flags_q[slot_q] <= FLAG_RUNNING;
					total_q <= total_q + CW'(1);
					if (total_q == '0 || cmp_le) begin
						head_q  <= slot_q;
						early_q <= dl_q;
						state_q <= ST_IDLE;
					end else begin
						prev_q  <= head_q;
						n_q     <= CW'(1);
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					// total_q already counts the new slot
					if (n_q >= total_q - CW'(1) || cmp_le) begin
						state_q <= ST_IDLE;
					end else begin
						prev_q <= rd_addr;
						n_q    <= n_q + CW'(1);
					end
				end
				ST_EXP: begin
					if (k_q < total_q && cmp_le) begin
						// The payload is only loaded once the previous word has gone.
						if (out_free) begin
							flags_q[cur_q] <= FLAG_ALLOC;
							o_slot_q <= 5'(cur_q);
							o_msg_q  <= msg_mem[cur_q];
							o_dq_q   <= 2'(q_mem[cur_q]);
							cur_q    <= rd_link;
							k_q      <= k_q + CW'(1);
							state_q  <= ST_OUT;
						end
					end else begin
						total_q <= total_q - k_q;
						head_q  <= cur_q;
						early_q <= (total_q != k_q) ? dl_mem[cur_q] : ALL_ONES;
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						o_valid_q <= 1'b1;
						o_kind_q  <= 1'b1;
						o_ok_q    <= 1'b0;
						o_last_q  <= !(k_q < total_q && cmp_le);
						state_q   <= ST_EXP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
